// ===== rtl/rtufr_pkg.sv =====
package rtufr_pkg;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_READ   = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_ADDR     = 3'd2,
    ST_CRC      = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_READ     = 3'd5,
    ST_READ_ERR = 3'd6
  } status_t;

  localparam logic [1:0] CFG_SLAVE_ADDR = 2'd0;
  localparam logic [1:0] CFG_MAX_LEN    = 2'd1;
  localparam logic [1:0] CFG_GAP_TICKS  = 2'd2;

  localparam logic [7:0]  SLAVE_ADDR_RST = 8'd1;
  localparam logic [8:0]  MAX_LEN_RST    = 9'd183;
  localparam logic [7:0]  GAP_TICKS_RST  = 8'd4;

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [8:0]  MIN_FRAME  = 9'd4;
  localparam int          FORMAT_MAX = 256;

  // result request handed from the frame control to the output stage
  typedef struct packed {
    logic       valid;
    status_t    status;
    logic [7:0] pdu_length;
  } res_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] x;
    x = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

endpackage

// ===== rtl/rtu_frame_receiver_unit.sv =====
// Modbus RTU frame receiver. Each request is a received line byte, a silence
// tick or a read of one PDU byte, and a new one may be accepted on every edge
// while results are taken; a waiting result with the output register still full
// holds the input off. Bytes go into a frame memory with one write port and one
// registered read port while the CRC-16 (init 0xFFFF, reflected poly 0xA001) is
// updated one byte per cycle as bytes are accepted, so closing a frame on the
// tick that exceeds gap_ticks needs no pass over the buffer. A result (frame
// status and PDU length, or a read byte) is registered in the frame control and
// loaded into the output register once that register is empty or being taken;
// a read byte comes from the registered memory read port. The accepted PDU stays
// readable until the next frame starts. Configuration writes are always taken
// and should only be made while the block is idle. No clearing pass follows reset.
module rtu_frame_receiver_unit
  import rtufr_pkg::*;
  #(
    parameter int BUFFER_BYTES = 256
  )
  (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] in_kind,
    input  logic [7:0] in_rx_byte,
    input  logic [7:0] in_read_index,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] out_status,
    output logic [7:0] out_pdu_length,
    output logic [7:0] out_pdu_byte,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [8:0] cfg_data
  );

  localparam int AW = $clog2(BUFFER_BYTES);

  logic          acc;
  logic          adv;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  res_t          res;

  logic          out_valid_r;
  status_t       out_status_r;
  logic [7:0]    out_len_r;
  logic [7:0]    out_byte_r;

  assign cfg_ready = 1'b1;
  assign adv       = res.valid && (!out_valid_r || out_ready);
  assign in_ready  = !res.valid || adv;
  assign acc       = in_valid && in_ready;

  rtufr_ctrl #(
    .BUFFER_BYTES(BUFFER_BYTES),
    .AW(AW)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .acc(acc),
    .adv(adv),
    .kind(in_kind),
    .rx_byte(in_rx_byte),
    .read_index(in_read_index),
    .cfg_we(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re(mem_re),
    .mem_raddr(mem_raddr),
    .res(res)
  );

  rtufr_store #(
    .BUFFER_BYTES(BUFFER_BYTES),
    .AW(AW)
  ) u_store (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re(mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_status_r <= res.status;
      out_len_r    <= res.pdu_length;
      out_byte_r   <= (res.status == ST_READ) ? mem_rdata : 8'd0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_pdu_length = out_len_r;
  assign out_pdu_byte   = out_byte_r;

  a_byte_only_on_read : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_READ) |-> out_pdu_byte == 8'd0)
    else $error("pdu byte set on a non-read result");

  a_len_zero_on_reject : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_SHORT || out_status == ST_ADDR ||
                  out_status == ST_CRC || out_status == ST_OVERFLOW)
    |-> out_pdu_length == 8'd0)
    else $error("pdu length set on a rejected frame");

  a_read_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_kind == KIND_READ) |=>
    res.valid && (res.status == ST_READ || res.status == ST_READ_ERR))
    else $error("read request without read result");

endmodule

// ===== rtl/rtufr_store.sv =====
module rtufr_store
  #(
    parameter int BUFFER_BYTES = 256,
    parameter int AW = 8
  )
  (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
  );

  logic [7:0] frame_mem [BUFFER_BYTES];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      frame_mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= frame_mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/rtufr_ctrl.sv =====
module rtufr_ctrl
  import rtufr_pkg::*;
  #(
    parameter int BUFFER_BYTES = 256,
    parameter int AW = 8
  )
  (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          acc,
    input  logic          adv,
    input  logic [1:0]    kind,
    input  logic [7:0]    rx_byte,
    input  logic [7:0]    read_index,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [8:0]    cfg_data,
    output logic          mem_we,
    output logic [AW-1:0] mem_waddr,
    output logic [7:0]    mem_wdata,
    output logic          mem_re,
    output logic [AW-1:0] mem_raddr,
    output res_t          res
  );

  localparam int         CAP     = (BUFFER_BYTES < FORMAT_MAX) ? BUFFER_BYTES : FORMAT_MAX;
  localparam logic [8:0] LIM_CAP = 9'(CAP);

  logic [7:0]  slave_r;
  logic [8:0]  max_len_r;
  logic [7:0]  gap_r;

  logic        open_r, open_nxt;
  logic [8:0]  cnt_r, cnt_nxt;
  logic [7:0]  sil_r, sil_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [7:0]  b1_r, b1_nxt;
  logic [7:0]  b2_r, b2_nxt;
  logic [15:0] crc_r, crc_nxt;
  res_t        res_r, res_nxt;

  logic [8:0]    lim;
  logic [8:0]    sil_inc;
  logic [8:0]    rd_pos;
  logic [AW+8:0] waddr_wide;
  logic [AW+8:0] raddr_wide;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_r   <= SLAVE_ADDR_RST;
      max_len_r <= MAX_LEN_RST;
      gap_r     <= GAP_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SLAVE_ADDR: slave_r   <= cfg_data[7:0];
        CFG_MAX_LEN:    max_len_r <= cfg_data;
        CFG_GAP_TICKS:  gap_r     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign lim        = (max_len_r > LIM_CAP) ? LIM_CAP : max_len_r;
  assign sil_inc    = {1'b0, sil_r} + 9'd1;
  assign rd_pos     = {1'b0, read_index} + 9'd1;
  assign waddr_wide = {{AW{1'b0}}, cnt_r};
  assign raddr_wide = {{AW{1'b0}}, rd_pos};
  assign mem_waddr  = waddr_wide[AW-1:0];
  assign mem_raddr  = raddr_wide[AW-1:0];
  assign mem_wdata  = rx_byte;

  always_comb begin
    open_nxt  = open_r;
    cnt_nxt   = cnt_r;
    sil_nxt   = sil_r;
    held_nxt  = held_r;
    first_nxt = first_r;
    b1_nxt    = b1_r;
    b2_nxt    = b2_r;
    crc_nxt   = crc_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    res_nxt   = res_r;
    if (adv) begin
      res_nxt.valid = 1'b0;
    end
    if (acc) begin
      res_nxt = '{valid: 1'b0, status: ST_OK, pdu_length: 8'd0};
      unique case (kind_t'(kind))
        KIND_BYTE: begin
          // count is zero whenever no frame is open
          if (!open_r) begin
            held_nxt = 8'd0;
          end
          open_nxt = 1'b1;
          sil_nxt  = 8'd0;
          if (cnt_r >= lim) begin
            open_nxt       = 1'b0;
            cnt_nxt        = 9'd0;
            res_nxt.valid  = 1'b1;
            res_nxt.status = ST_OVERFLOW;
          end else begin
            mem_we  = 1'b1;
            cnt_nxt = cnt_r + 9'd1;
            b1_nxt  = rx_byte;
            b2_nxt  = b1_r;
            if (cnt_r == 9'd0) begin
              first_nxt = rx_byte;
              crc_nxt   = CRC_INIT;
            end else if (cnt_r >= 9'd2) begin
              // crc trails by two bytes so it never covers the received crc
              crc_nxt = crc16_byte(crc_r, b2_r);
            end
          end
        end
        KIND_TICK: begin
          if (open_r) begin
            if (sil_inc <= {1'b0, gap_r}) begin
              sil_nxt = sil_inc[7:0];
            end else begin
              open_nxt      = 1'b0;
              cnt_nxt       = 9'd0;
              sil_nxt       = 8'd0;
              res_nxt.valid = 1'b1;
              priority if (cnt_r < MIN_FRAME) begin
                res_nxt.status = ST_SHORT;
              end else if (first_r != slave_r) begin
                res_nxt.status = ST_ADDR;
              end else if ({b1_r, b2_r} != crc_r) begin
                res_nxt.status = ST_CRC;
              end else begin
                res_nxt.status     = ST_OK;
                res_nxt.pdu_length = 8'(cnt_r - 9'd3);
                held_nxt           = 8'(cnt_r - 9'd3);
              end
            end
          end
        end
        KIND_READ: begin
          res_nxt.valid      = 1'b1;
          res_nxt.pdu_length = held_r;
          if (read_index < held_r) begin
            res_nxt.status = ST_READ;
            mem_re         = 1'b1;
          end else begin
            res_nxt.status = ST_READ_ERR;
          end
        end
        KIND_UNUSED: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r    <= 1'b0;
      cnt_r     <= 9'd0;
      sil_r     <= 8'd0;
      held_r    <= 8'd0;
      res_r     <= '{valid: 1'b0, status: ST_OK, pdu_length: 8'd0};
    end else begin
      open_r    <= open_nxt;
      cnt_r     <= cnt_nxt;
      sil_r     <= sil_nxt;
      held_r    <= held_nxt;
      res_r     <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt;
    b1_r    <= b1_nxt;
    b2_r    <= b2_nxt;
    crc_r   <= crc_nxt;
  end

  assign res = res_r;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import rtufr_pkg::*;

  localparam int BUF_BYTES   = 256;
  localparam int SETTLE      = 8;
  localparam int HOLD_CYCLES = 200;
  localparam int FILL_RANDOM = 0;
  localparam int FILL_ZERO   = 1;
  localparam int FILL_ONES   = 2;

  typedef struct {
    status_t    status;
    logic [7:0] pdu_length;
    logic [7:0] pdu_byte;
  } rtu_response_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_kind = KIND_UNUSED;
  logic [7:0] in_rx_byte = 8'h00;
  logic [7:0] in_read_index = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_status;
  logic [7:0] out_pdu_length;
  logic [7:0] out_pdu_byte;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = CFG_SLAVE_ADDR;
  logic [8:0] cfg_data = 9'd0;

  // predicted block state and register copies
  logic [7:0] frame_copy [BUF_BYTES];
  int         frame_fill = 0;
  bit         frame_is_open = 1'b0;
  int         silence_run = 0;
  int         held_pdu_len = 0;
  logic [7:0] slave_addr_set = SLAVE_ADDR_RST;
  int         max_len_set = MAX_LEN_RST;
  int         gap_set = GAP_TICKS_RST;

  rtu_response_t pending_responses[$];
  rtu_response_t head_response;
  logic [7:0]    frame_buf[$];

  int errors = 0;
  int items_sent = 0;
  int responses_checked = 0;
  int config_loads = 0;
  int accepted_frames = 0;
  int rejected_frames = 0;
  int overflow_count = 0;
  int read_count = 0;
  int burst_left = 0;
  int drain_guard = 0;
  bit steady_feed = 1'b0;
  bit hold_go = 1'b0;

  rtu_frame_receiver_unit #(.BUFFER_BYTES(BUF_BYTES)) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_rx_byte     (in_rx_byte),
    .in_read_index  (in_read_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_pdu_length (out_pdu_length),
    .out_pdu_byte   (out_pdu_byte),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: done, errors");
    $finish;
  end

  function automatic void flag_error(string msg);
    errors++;
    if (errors <= 10) begin
      $display("%0t tb: %s", $time, msg);
    end
  endfunction

  // modbus crc, one data bit at a time
  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] data);
    logic fb;
    for (int b = 0; b < 8; b++) begin
      fb = crc[0] ^ data[b];
      crc = crc >> 1;
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

  function automatic void predict_response(kind_t k, logic [7:0] rx, logic [7:0] ix);
    rtu_response_t r;
    bit            emit;
    int            lim;
    logic [15:0]   crc;
    logic [15:0]   got;
    emit = 1'b0;
    r.status = ST_OK;
    r.pdu_length = 8'd0;
    r.pdu_byte = 8'd0;
    lim = (max_len_set > BUF_BYTES) ? BUF_BYTES : max_len_set;
    if (lim > FORMAT_MAX) begin
      lim = FORMAT_MAX;
    end
    case (k)
      KIND_BYTE: begin
        if (!frame_is_open) begin
          frame_is_open = 1'b1;
          frame_fill = 0;
          held_pdu_len = 0;
        end
        silence_run = 0;
        if (frame_fill + 1 > lim) begin
          frame_is_open = 1'b0;
          frame_fill = 0;
          r.status = ST_OVERFLOW;
          emit = 1'b1;
          overflow_count++;
        end else begin
          frame_copy[frame_fill] = rx;
          frame_fill++;
        end
      end
      KIND_TICK: begin
        if (frame_is_open) begin
          if (silence_run + 1 <= gap_set) begin
            silence_run++;
          end else begin
            emit = 1'b1;
            if (frame_fill < MIN_FRAME) begin
              r.status = ST_SHORT;
            end else if (frame_copy[0] != slave_addr_set) begin
              r.status = ST_ADDR;
            end else begin
              crc = CRC_INIT;
              for (int i = 0; i < frame_fill - 2; i++) begin
                crc = crc_step(crc, frame_copy[i]);
              end
              got = {frame_copy[frame_fill - 1], frame_copy[frame_fill - 2]};
              if (got != crc) begin
                r.status = ST_CRC;
              end else begin
                held_pdu_len = frame_fill - 3;
                r.pdu_length = 8'(held_pdu_len);
              end
            end
            if (r.status == ST_OK) accepted_frames++;
            else rejected_frames++;
            frame_is_open = 1'b0;
            frame_fill = 0;
            silence_run = 0;
          end
        end
      end
      KIND_READ: begin
        emit = 1'b1;
        read_count++;
        r.pdu_length = 8'(held_pdu_len);
        if (ix < held_pdu_len) begin
          r.status = ST_READ;
          r.pdu_byte = frame_copy[ix + 1];
        end else begin
          r.status = ST_READ_ERR;
        end
      end
      default: ;
    endcase
    if (emit) begin
      pending_responses.push_back(r);
    end
  endfunction

  // one request; the sender may idle between bursts unless the feed is steady
  task automatic send_item(kind_t k, logic [7:0] rx, logic [7:0] ix);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady_feed ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_kind <= k;
    in_rx_byte <= rx;
    in_read_index <= ix;
    do @(posedge clk); while (!in_ready);
    predict_response(k, rx, ix);
    if (k != KIND_UNUSED) begin
      items_sent++;
    end
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(KIND_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  task automatic send_read(int ix);
    send_item(KIND_READ, 8'($urandom_range(0, 255)), 8'(ix));
  endtask

  // frame bytes with silence inside the gap now and then
  task automatic send_frame_buf();
    foreach (frame_buf[i]) begin
      send_item(KIND_BYTE, frame_buf[i], 8'($urandom_range(0, 255)));
      if (gap_set > 0 && $urandom_range(0, 7) == 0) begin
        send_ticks($urandom_range(1, gap_set));
      end
    end
  endtask

  task automatic close_frame();
    send_ticks(gap_set + 1);
  endtask

  task automatic read_all_held();
    for (int i = 0; i <= held_pdu_len; i++) begin
      send_read(i);
    end
    send_read(255);
  endtask

  function automatic void build_frame(logic [7:0] addr, int pdu_len, bit corrupt, int fill);
    logic [15:0] crc;
    frame_buf.delete();
    frame_buf.push_back(addr);
    for (int i = 0; i < pdu_len; i++) begin
      if (fill == FILL_ZERO) frame_buf.push_back(8'h00);
      else if (fill == FILL_ONES) frame_buf.push_back(8'hFF);
      else frame_buf.push_back(8'($urandom_range(0, 255)));
    end
    crc = CRC_INIT;
    foreach (frame_buf[i]) begin
      crc = crc_step(crc, frame_buf[i]);
    end
    if (corrupt) begin
      crc = crc ^ (16'd1 << $urandom_range(0, 15));
    end
    frame_buf.push_back(crc[7:0]);
    frame_buf.push_back(crc[15:8]);
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [8:0] val);
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_config(logic [7:0] addr, logic [8:0] max_len, logic [7:0] gap);
    in_valid <= 1'b0;
    write_reg(CFG_SLAVE_ADDR, {1'b0, addr});
    write_reg(CFG_MAX_LEN, max_len);
    write_reg(CFG_GAP_TICKS, {1'b0, gap});
    slave_addr_set = addr;
    max_len_set = max_len;
    gap_set = gap;
    config_loads++;
  endtask

  task automatic test_reset_values();
    send_ticks(1);
    send_read(0);
    send_item(KIND_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    build_frame(SLAVE_ADDR_RST, 3, 1'b0, FILL_RANDOM);
    send_frame_buf();
    close_frame();
    read_all_held();
    // a new frame drops the held pdu
    send_item(KIND_BYTE, SLAVE_ADDR_RST, 8'h00);
    send_read(0);
    close_frame();
  endtask

  task automatic test_frame_checks();
    load_config(8'h00, 9'd183, 8'd0);
    build_frame(8'h00, 2, 1'b0, FILL_RANDOM);
    frame_buf.delete(3);
    frame_buf.delete(2);
    send_frame_buf();
    close_frame();
    build_frame(8'h5A, 1, 1'b0, FILL_RANDOM);
    send_frame_buf();
    close_frame();
    build_frame(8'h00, 3, 1'b1, FILL_RANDOM);
    send_frame_buf();
    close_frame();
    send_read(0);
    build_frame(8'h00, 4, 1'b0, FILL_ZERO);
    send_frame_buf();
    close_frame();
    read_all_held();
  endtask

  task automatic test_length_limit();
    load_config(8'hFF, 9'd4, 8'd0);
    build_frame(8'hFF, 2, 1'b0, FILL_ONES);
    send_frame_buf();
    build_frame(8'hFF, 1, 1'b0, FILL_ONES);
    send_frame_buf();
    close_frame();
    send_read(0);
    send_read(1);
    load_config(8'hFF, 9'd256, 8'd0);
    build_frame(8'hFF, 253, 1'b0, FILL_RANDOM);
    send_frame_buf();
    close_frame();
    send_read(0);
    send_read(252);
    send_read(253);
  endtask

  task automatic test_longest_gap();
    load_config(8'h01, 9'd16, 8'd255);
    build_frame(8'h01, 2, 1'b0, FILL_RANDOM);
    send_frame_buf();
    send_ticks(255);
    send_ticks(1);
    send_read(1);
  endtask

  task automatic test_back_pressure();
    load_config(8'h33, 9'd64, 8'd2);
    steady_feed = 1'b1;
    build_frame(8'h33, 20, 1'b0, FILL_RANDOM);
    send_frame_buf();
    close_frame();
    hold_go = 1'b1;
    repeat (60) send_read($urandom_range(0, held_pdu_len + 1));
    steady_feed = 1'b0;
  endtask

  task automatic random_frame();
    int         lim;
    int         sel;
    int         plen;
    int         cap;
    logic [7:0] addr;
    lim = (max_len_set > BUF_BYTES) ? BUF_BYTES : max_len_set;
    cap = (lim - 3 < 12) ? lim - 3 : 12;
    sel = $urandom_range(0, 99);
    plen = ($urandom_range(0, 9) == 0) ? $urandom_range(1, lim - 3) : $urandom_range(1, cap);
    addr = slave_addr_set;
    if (sel < 8) begin
      addr = slave_addr_set ^ 8'($urandom_range(1, 255));
    end
    build_frame(addr, plen, sel >= 8 && sel < 16, FILL_RANDOM);
    if (sel >= 16 && sel < 22) begin
      sel = $urandom_range(1, 3);
      while (frame_buf.size() > sel) frame_buf.delete(frame_buf.size() - 1);
    end else if (sel >= 22 && sel < 27) begin
      while (frame_buf.size() <= lim) frame_buf.push_back(8'($urandom_range(0, 255)));
    end
    send_frame_buf();
    send_ticks(gap_set + 1 + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0));
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 3) == 0) send_read($urandom_range(0, 255));
      else send_read($urandom_range(0, held_pdu_len + 1));
    end
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        send_item(kind_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      end
    end
  endtask

  // random rounds until the total request count reaches the target
  task automatic test_random_traffic(int target);
    int         stop_at;
    int         pick;
    logic [7:0] addr;
    logic [8:0] max_len;
    logic [7:0] gap;
    stop_at = target;
    do begin
      pick = $urandom_range(0, 9);
      addr = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 9);
      max_len = (pick < 2) ? 9'd4 : (pick == 2) ? 9'd256 : 9'($urandom_range(5, 40));
      pick = $urandom_range(0, 9);
      gap = (pick < 2) ? 8'd0 : (pick == 2) ? 8'($urandom_range(7, 20)) :
            8'($urandom_range(1, 6));
      load_config(addr, max_len, gap);
      steady_feed = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(4, 10)) random_frame();
    end while (items_sent < stop_at);
    steady_feed = 1'b0;
  endtask

  // receiver: stall pattern of its own, plus one long hold on request
  initial begin : receiver
    int mode;
    int mode_left;
    mode = 0;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 150);
        end
        mode_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      responses_checked++;
      if (pending_responses.size() == 0) begin
        flag_error($sformatf("unexpected response: status %0d len %0d byte %02h",
                             out_status, out_pdu_length, out_pdu_byte));
      end else begin
        head_response = pending_responses.pop_front();
        if (out_status !== head_response.status ||
            out_pdu_length !== head_response.pdu_length ||
            out_pdu_byte !== head_response.pdu_byte) begin
          flag_error($sformatf(
            "mismatch: expected status %0d len %0d byte %02h, got status %0d len %0d byte %02h",
            head_response.status, head_response.pdu_length, head_response.pdu_byte,
            out_status, out_pdu_length, out_pdu_byte));
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_frame_checks();
    test_length_limit();
    test_longest_gap();
    test_back_pressure();
    test_random_traffic(850);
    in_valid <= 1'b0;
    while (pending_responses.size() != 0 && drain_guard < 20000) begin
      @(posedge clk);
      drain_guard++;
    end
    repeat (SETTLE) @(posedge clk);
    if (pending_responses.size() != 0) begin
      flag_error($sformatf("%0d responses never arrived", pending_responses.size()));
    end
    $display("tb: %0d requests, %0d responses checked, %0d register loads",
             items_sent, responses_checked, config_loads);
    $display("tb: frames accepted %0d, rejected %0d, overflows %0d, reads %0d",
             accepted_frames, rejected_frames, overflow_count, read_count);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rtufr_pkg.sv
rtl/rtufr_store.sv
rtl/rtufr_ctrl.sv
rtl/rtu_frame_receiver_unit.sv
sim/tb.sv
